>>> rtl/core/ali_pkg.sv
// ----------------------------------------------------------------------------
// ali_pkg
// Shared widths, constants, codes and unit interface types of the adaptive
// leaky integrator.
// ----------------------------------------------------------------------------
package ali_pkg;

  localparam int DATA_W    = 32;
  localparam int ERR_W     = 33;
  localparam int TS_W      = 48;
  localparam int WGT_W     = 24;
  localparam int LIM_W     = 31;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int EXP_Q     = 30;
  localparam int MUL_SHIFT = 36;

  // digit-serial multiplier: 64 x 64 bits, four multiplier bits per cycle
  localparam int DIG_W     = 4;
  localparam int MUL_AW    = 64;
  localparam int MUL_BW    = 64;
  localparam int MUL_PW    = MUL_AW + MUL_BW;
  localparam int MUL_STEPS = MUL_BW / DIG_W;
  localparam int MUL_CW    = $clog2(MUL_STEPS);

  // bit-serial divider for the series term divisions
  localparam int DIV_NW    = 31;
  localparam int DIV_DW    = 5;
  localparam int DIV_CW    = $clog2(DIV_NW);

  localparam int SERIES_TERMS = 16;
  localparam int W_MIN_Q16    = 6554;
  localparam int W_MAX_Q16    = 655360;

  localparam logic [EXP_Q:0] Q30_ONE = 31'h4000_0000;
  // exp(-1) in Q30 as the truncated 17-term series gives it
  localparam logic [EXP_Q:0] E1_Q30  = 31'd395007543;
  // decay_rate * dt at or above 23.0 in Q36 sets the decay factor to zero
  localparam logic [79:0]    DECAY_CUT = 80'd23 << MUL_SHIFT;

  typedef enum logic [CFG_AW-1:0] {
    REG_DECAY_RATE   = 3'd0,
    REG_WEIGHT_BASE  = 3'd1,
    REG_WEIGHT_GAIN  = 3'd2,
    REG_ADAPTIVE_EN  = 3'd3,
    REG_OUTPUT_LIMIT = 3'd4,
    REG_OUTPUT_GAIN  = 3'd5,
    REG_INVERT       = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STAT_UPDATED   = 3'd0,
    STAT_FIRST     = 3'd1,
    STAT_ZERO_STEP = 3'd2,
    STAT_BACKWARDS = 3'd3,
    STAT_CLEARED   = 3'd4
  } status_t;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } ali_mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } ali_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ali_unit_sts_t;

endpackage

>>> rtl/core/ali_mul.sv
// ----------------------------------------------------------------------------
// ali_mul
// Digit-serial unsigned multiplier: the multiplier operand shifts out four
// bits per cycle while partial sums shift into the product register.
// ----------------------------------------------------------------------------
module ali_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ali_pkg::ali_mul_req_t               req,
  output ali_pkg::ali_unit_sts_t              sts,
  output logic [ali_pkg::MUL_PW-1:0]          prod
);
  import ali_pkg::*;

  logic [MUL_AW-1:0]       a_r;
  logic [MUL_PW-1:0]       p_r;
  logic [MUL_CW-1:0]       cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic [MUL_AW+DIG_W-1:0] part;
  logic [MUL_AW+DIG_W-1:0] sum;
  logic [MUL_PW-1:0]       p_nxt;

  always_comb begin
    part = '0;
    for (int i = 0; i < DIG_W; i++) begin
      if (p_r[i]) begin
        part = part + ({{DIG_W{1'b0}}, a_r} << i);
      end
    end
    sum   = {{DIG_W{1'b0}}, p_r[MUL_PW-1:MUL_BW]} + part;
    p_nxt = {sum, p_r[MUL_BW-1:DIG_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        p_r    <= {{MUL_AW{1'b0}}, req.b};
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        p_r   <= p_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CW'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = p_r;

endmodule

>>> rtl/core/ali_div.sv
// ----------------------------------------------------------------------------
// ali_div
// Bit-serial restoring divider of a 31-bit value by a small divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module ali_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ali_pkg::ali_div_req_t               req,
  output ali_pkg::ali_unit_sts_t              sts,
  output logic [ali_pkg::DIV_NW-1:0]          quot
);
  import ali_pkg::*;

  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   cand;
  logic [DIV_DW:0]   diff;
  logic              ge;
  logic [DIV_DW-1:0] rem_nxt;

  always_comb begin
    cand    = {rem_r, q_r[DIV_NW-1]};
    diff    = cand - {1'b0, den_r};
    ge      = cand >= {1'b0, den_r};
    rem_nxt = ge ? diff[DIV_DW-1:0] : cand[DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r    <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[DIV_NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = q_r;

endmodule

>>> rtl/core/adaptive_leaky_integrator.sv
// ----------------------------------------------------------------------------
// adaptive_leaky_integrator
// Leaky, optionally error-weighted integrator with a scaled, saturated drive.
//
// Channel   Dir  Handshake            Contents
// in_       in   in_tvalid/in_tready  tdata measured, target, timestamp; tuser action
// out_      out  out_tvalid/out_tready tdata drive, integral, error, bound; tuser status
// cfg_      in   cfg_we               cfg_addr register index, cfg_wdata value
//
// One item at a time; every product comes from the shared digit-serial multiplier
// and each series term division from the bit-serial divider. Clear, first sample
// and skipped steps go straight to the drive product. An update runs the series,
// then one multiplier pass per unit of n, the whole part of decay_rate * dt (0 to 22);
// adaptive weighting adds one pass. When decay_rate * dt reaches 23 the series is
// skipped.
// Reset is synchronous; a waiting result does not block the next transfer in.
// ----------------------------------------------------------------------------
module adaptive_leaky_integrator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // measured[31:0], target[63:32], timestamp[111:64]
  input  logic         in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // drive[31:0], integral[63:32], error_value[96:64],
                                   // within_bound[97], zero fill
  output logic [2:0]   out_tuser,  // status
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import ali_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_W_GO, S_W_WAIT, S_W_SET, S_R_GO, S_R_WAIT, S_T_GO, S_T_WAIT,
    S_K_GO, S_K_WAIT, S_E_GO, S_E_WAIT, S_I_GO, S_I_WAIT, S_M_GO, S_M_WAIT,
    S_N_GO, S_N_WAIT, S_ADD, S_CLAMP, S_D_GO, S_D_WAIT, S_OUT
  } state_t;

  localparam logic signed [42:0]  W_LO     = 43'(W_MIN_Q16);
  localparam logic signed [42:0]  W_HI     = 43'(W_MAX_Q16);
  localparam logic signed [32:0]  S_ONE    = 33'sd1073741824;
  localparam logic [59:0]         E_RND    = 60'h2000_0000;
  localparam logic [63:0]         I_RND    = 64'h2000_0000;
  localparam logic [63:0]         D_RND    = 64'h8000;
  localparam logic [105:0]        N_RND    = 106'(1) << (MUL_SHIFT - 1);
  localparam logic [62:0]         Q_CAP    = 63'(1) << 62;
  localparam logic signed [41:0]  DRV_MAX  = 42'sd2147483647;
  localparam logic signed [41:0]  DRV_MIN  = -42'sd2147483648;

  // configuration
  logic [31:0]              decay_rate_r;
  logic signed [WGT_W-1:0]  weight_base_r;
  logic signed [WGT_W-1:0]  weight_gain_r;
  logic                     adaptive_r;
  logic [LIM_W-1:0]         limit_r;
  logic signed [WGT_W-1:0]  out_gain_r;
  logic                     invert_r;

  // state and working registers
  state_t                   state_r;
  logic signed [DATA_W-1:0] integral_r;
  logic [TS_W-1:0]          last_time_r;
  logic                     started_r;
  logic signed [ERR_W-1:0]  err_r;
  logic [TS_W-1:0]          ts_r;
  logic [TS_W-1:0]          dt_r;
  status_t                  status_r;
  logic signed [WGT_W-1:0]  w_r;
  logic [40:0]              wt_r;
  logic [4:0]               n_r;
  logic [29:0]              f_r;
  logic [30:0]              term_r;
  logic signed [32:0]       sum_r;
  logic [4:0]               k_r;
  logic [30:0]              tq_r;
  logic [30:0]              d_r;
  logic signed [32:0]       v_r;
  logic [56:0]              mag_r;
  logic                     neg_r;
  logic [62:0]              q_r;
  logic signed [64:0]       acc_r;
  logic signed [40:0]       dr_r;
  logic                     out_tvalid_r;
  logic [103:0]             out_data_r;
  status_t                  out_status_r;

  // units
  ali_mul_req_t             mreq;
  ali_unit_sts_t            msts;
  logic [MUL_PW-1:0]        mprod;
  ali_div_req_t             dreq;
  ali_unit_sts_t            dsts;
  logic [DIV_NW-1:0]        dquot;

  // input fields
  logic signed [31:0]       in_measured;
  logic signed [31:0]       in_target;
  logic [TS_W-1:0]          in_ts;
  logic signed [ERR_W-1:0]  err_in;
  logic [TS_W-1:0]          dt_in;
  logic                     accept;

  // datapath
  logic [32:0]              e_mag;
  logic [23:0]              wg_mag;
  logic [23:0]              w_mag;
  logic [31:0]              i_mag;
  logic [23:0]              og_mag;
  logic [56:0]              w_pu;
  logic signed [42:0]       w_base_x;
  logic signed [42:0]       w_add;
  logic signed [42:0]       w_sum;
  logic signed [WGT_W-1:0]  w_nxt;
  logic                     decay_none;
  logic signed [32:0]       qk_x;
  logic signed [32:0]       sum_nxt;
  logic [30:0]              d_series;
  logic [59:0]              e_rnd;
  logic [63:0]              i_s;
  logic [105:0]             n_rr;
  logic [62:0]              q_nxt;
  logic signed [64:0]       v_x;
  logic signed [64:0]       q_x;
  logic signed [64:0]       acc_nxt;
  logic signed [64:0]       lim_p;
  logic signed [64:0]       lim_n;
  logic signed [64:0]       clamp_val;
  logic [63:0]              d_s;
  logic signed [41:0]       dr_x;
  logic signed [41:0]       dn;
  logic [31:0]              drive_nxt;
  logic                     within_nxt;
  logic                     out_free;

  assign in_measured = in_tdata[31:0];
  assign in_target   = in_tdata[63:32];
  assign in_ts       = in_tdata[111:64];
  assign err_in      = {in_measured[31], in_measured} - {in_target[31], in_target};
  assign dt_in       = in_ts - last_time_r;
  assign in_tready   = (state_r == S_IDLE);
  assign accept      = in_tvalid && in_tready;
  assign out_free    = !out_tvalid_r || out_tready;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_rate_r  <= 32'd65536;
      weight_base_r <= 24'sd65536;
      weight_gain_r <= '0;
      adaptive_r    <= 1'b0;
      limit_r       <= 31'd6553600;
      out_gain_r    <= 24'sd65536;
      invert_r      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DECAY_RATE:   decay_rate_r  <= cfg_wdata;
        REG_WEIGHT_BASE:  weight_base_r <= cfg_wdata[WGT_W-1:0];
        REG_WEIGHT_GAIN:  weight_gain_r <= cfg_wdata[WGT_W-1:0];
        REG_ADAPTIVE_EN:  adaptive_r    <= cfg_wdata[0];
        REG_OUTPUT_LIMIT: limit_r       <= cfg_wdata[LIM_W-1:0];
        REG_OUTPUT_GAIN:  out_gain_r    <= cfg_wdata[WGT_W-1:0];
        REG_INVERT:       invert_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // magnitudes and per-step arithmetic
  // --------------------------------------------------------------------------
  always_comb begin
    e_mag  = err_r[ERR_W-1] ? 33'(-err_r) : 33'(err_r);
    wg_mag = weight_gain_r[WGT_W-1] ? 24'(-weight_gain_r) : 24'(weight_gain_r);
    w_mag  = w_r[WGT_W-1] ? 24'(-w_r) : 24'(w_r);
    i_mag  = integral_r[DATA_W-1] ? 32'(-integral_r) : 32'(integral_r);
    og_mag = out_gain_r[WGT_W-1] ? 24'(-out_gain_r) : 24'(out_gain_r);

    // floor shift of a negative gain product rounds the magnitude up
    w_pu     = (mprod[56:0] + (weight_gain_r[WGT_W-1] ? 57'h0FFFF : 57'h0)) >> 16;
    w_base_x = {{19{weight_base_r[WGT_W-1]}}, weight_base_r};
    w_add    = {2'b00, wt_r};
    w_sum    = weight_gain_r[WGT_W-1] ? (w_base_x - w_add) : (w_base_x + w_add);
    if (w_sum < W_LO) begin
      w_nxt = 24'(W_MIN_Q16);
    end else if (w_sum > W_HI) begin
      w_nxt = 24'(W_MAX_Q16);
    end else begin
      w_nxt = w_sum[WGT_W-1:0];
    end

    decay_none = (mprod[79:0] >= DECAY_CUT);

    qk_x    = {2'b00, dquot};
    sum_nxt = k_r[0] ? (sum_r - qk_x) : (sum_r + qk_x);
    if (sum_nxt < 0) begin
      d_series = '0;
    end else if (sum_nxt > S_ONE) begin
      d_series = Q30_ONE;
    end else begin
      d_series = sum_nxt[30:0];
    end

    e_rnd = mprod[59:0] + E_RND;

    i_s = integral_r[DATA_W-1] ? (I_RND - {1'b0, mprod[62:0]})
                               : ({1'b0, mprod[62:0]} + I_RND);

    n_rr  = {1'b0, mprod[104:0]} + N_RND;
    q_nxt = (n_rr[105:36] > 70'(Q_CAP)) ? Q_CAP : n_rr[98:36];

    v_x     = {{32{v_r[32]}}, v_r};
    q_x     = {2'b00, q_r};
    acc_nxt = neg_r ? (v_x - q_x) : (v_x + q_x);

    lim_p = {34'b0, limit_r};
    lim_n = -lim_p;
    if (acc_r > lim_p) begin
      clamp_val = lim_p;
    end else if (acc_r < lim_n) begin
      clamp_val = lim_n;
    end else begin
      clamp_val = acc_r;
    end

    d_s = (integral_r[DATA_W-1] ^ out_gain_r[WGT_W-1]) ? (D_RND - {8'b0, mprod[55:0]})
                                                       : ({8'b0, mprod[55:0]} + D_RND);

    dr_x = {dr_r[40], dr_r};
    dn   = invert_r ? -dr_x : dr_x;
    if (dn > DRV_MAX) begin
      drive_nxt = 32'h7FFF_FFFF;
    end else if (dn < DRV_MIN) begin
      drive_nxt = 32'h8000_0000;
    end else begin
      drive_nxt = dn[31:0];
    end
    within_nxt = (i_mag <= {1'b0, limit_r});
  end

  // --------------------------------------------------------------------------
  // unit requests
  // --------------------------------------------------------------------------
  always_comb begin
    mreq = '0;
    unique case (state_r)
      S_W_GO: begin
        mreq.start = 1'b1;
        mreq.a     = 64'(wg_mag);
        mreq.b     = 64'(e_mag);
      end
      S_R_GO: begin
        mreq.start = 1'b1;
        mreq.a     = 64'(decay_rate_r);
        mreq.b     = 64'(dt_r);
      end
      S_T_GO: begin
        mreq.start = 1'b1;
        mreq.a     = 64'(term_r);
        mreq.b     = 64'(f_r);
      end
      S_E_GO: begin
        mreq.start = 1'b1;
        mreq.a     = 64'(d_r);
        mreq.b     = 64'(E1_Q30);
      end
      S_I_GO: begin
        mreq.start = 1'b1;
        mreq.a     = 64'(i_mag);
        mreq.b     = 64'(d_r);
      end
      S_M_GO: begin
        mreq.start = 1'b1;
        mreq.a     = 64'(w_mag);
        mreq.b     = 64'(e_mag);
      end
      S_N_GO: begin
        mreq.start = 1'b1;
        mreq.a     = 64'(mag_r);
        mreq.b     = 64'(dt_r);
      end
      S_D_GO: begin
        mreq.start = 1'b1;
        mreq.a     = 64'(i_mag);
        mreq.b     = 64'(og_mag);
      end
      default: ;
    endcase
  end

  assign dreq.start = (state_r == S_K_GO);
  assign dreq.num   = tq_r;
  assign dreq.den   = k_r;

  ali_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .sts   (msts),
    .prod  (mprod)
  );

  ali_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .sts   (dsts),
    .quot  (dquot)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      integral_r   <= '0;
      last_time_r  <= '0;
      started_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            err_r <= err_in;
            ts_r  <= in_ts;
            dt_r  <= dt_in;
            if (in_tuser) begin
              integral_r  <= '0;
              last_time_r <= '0;
              started_r   <= 1'b0;
              status_r    <= STAT_CLEARED;
              state_r     <= S_D_GO;
            end else if (!started_r) begin
              integral_r  <= '0;
              last_time_r <= in_ts;
              started_r   <= 1'b1;
              status_r    <= STAT_FIRST;
              state_r     <= S_D_GO;
            end else if (in_ts < last_time_r) begin
              status_r <= STAT_BACKWARDS;
              state_r  <= S_D_GO;
            end else if (in_ts == last_time_r) begin
              status_r <= STAT_ZERO_STEP;
              state_r  <= S_D_GO;
            end else begin
              status_r <= STAT_UPDATED;
              w_r      <= weight_base_r;
              state_r  <= adaptive_r ? S_W_GO : S_R_GO;
            end
          end
        end
        S_W_GO:   state_r <= S_W_WAIT;
        S_W_WAIT: begin
          if (msts.done) begin
            wt_r    <= w_pu[40:0];
            state_r <= S_W_SET;
          end
        end
        S_W_SET: begin
          w_r     <= w_nxt;
          state_r <= S_R_GO;
        end
        S_R_GO:   state_r <= S_R_WAIT;
        S_R_WAIT: begin
          if (msts.done) begin
            if (decay_none) begin
              d_r     <= '0;
              state_r <= S_I_GO;
            end else begin
              n_r     <= mprod[40:36];
              f_r     <= mprod[35:6];
              term_r  <= Q30_ONE;
              sum_r   <= S_ONE;
              k_r     <= 5'd1;
              state_r <= S_T_GO;
            end
          end
        end
        S_T_GO:   state_r <= S_T_WAIT;
        S_T_WAIT: begin
          if (msts.done) begin
            tq_r    <= mprod[60:30];
            state_r <= S_K_GO;
          end
        end
        S_K_GO:   state_r <= S_K_WAIT;
        S_K_WAIT: begin
          if (dsts.done) begin
            term_r <= dquot;
            sum_r  <= sum_nxt;
            if (k_r == 5'(SERIES_TERMS)) begin
              d_r     <= d_series;
              state_r <= (n_r == '0) ? S_I_GO : S_E_GO;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_T_GO;
            end
          end
        end
        S_E_GO:   state_r <= S_E_WAIT;
        S_E_WAIT: begin
          // one whole unit of decay per pass
          if (msts.done) begin
            d_r     <= {1'b0, e_rnd[59:30]};
            n_r     <= n_r - 1'b1;
            state_r <= (n_r == 5'd1) ? S_I_GO : S_E_GO;
          end
        end
        S_I_GO:   state_r <= S_I_WAIT;
        S_I_WAIT: begin
          if (msts.done) begin
            v_r     <= i_s[62:30];
            state_r <= S_M_GO;
          end
        end
        S_M_GO:   state_r <= S_M_WAIT;
        S_M_WAIT: begin
          if (msts.done) begin
            mag_r   <= mprod[56:0];
            neg_r   <= w_r[WGT_W-1] ^ err_r[ERR_W-1];
            state_r <= S_N_GO;
          end
        end
        S_N_GO:   state_r <= S_N_WAIT;
        S_N_WAIT: begin
          if (msts.done) begin
            q_r     <= q_nxt;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          acc_r   <= acc_nxt;
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          integral_r  <= clamp_val[DATA_W-1:0];
          last_time_r <= ts_r;
          state_r     <= S_D_GO;
        end
        S_D_GO:   state_r <= S_D_WAIT;
        S_D_WAIT: begin
          if (msts.done) begin
            dr_r    <= d_s[56:16];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= {6'b0, within_nxt, err_r, integral_r, drive_nxt};
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser) |=> (integral_r == '0 && !started_r && last_time_r == '0))
    else $error("clear transfer did not reset the integrator state");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.start |-> !msts.busy)
    else $error("multiplier started while busy");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> !dsts.busy)
    else $error("divider started while busy");

  a_units_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!msts.busy && !dsts.busy))
    else $error("arithmetic unit still busy while accepting input");

endmodule
